/* rtl/icca_pkg.sv */
// Package: constants, types and state codes for the interval column assign block.
`default_nettype none
package icca_pkg;
  localparam int unsigned MaxEntriesDef = 32;
  localparam int unsigned StartW = 17;
  localparam int unsigned EndW = 18;
  localparam int unsigned IdxW = 5;
  localparam int unsigned CntW = 6;
  localparam logic [EndW-1:0] DaySeconds = 18'd86400;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_CL_RD,
    ST_CL_CHK,
    ST_COL_RD,
    ST_COL_ENT,
    ST_COL_CHK,
    ST_OUT_RD,
    ST_OUT_EMIT
  } state_e;

  // Reduce a 17-bit value below one day.
  function automatic logic [StartW-1:0] wrap17(input logic [StartW-1:0] v);
    logic [EndW-1:0] w;
    w = {1'b0, v};
    if (w >= DaySeconds) w = w - DaySeconds;
    return w[StartW-1:0];
  endfunction

  // End of an interval, pushed past midnight when it wraps.
  function automatic logic [EndW-1:0] calc_end(input logic [StartW-1:0] s,
                                               input logic [StartW-1:0] d);
    logic [EndW-1:0] t;
    t = {1'b0, s} + {1'b0, d};
    if (t >= DaySeconds) t = t - DaySeconds;
    if (t < {1'b0, s}) t = t + DaySeconds;
    return t;
  endfunction
endpackage
`default_nettype wire

/* rtl/icca_if.sv */
// Handshake channel interfaces for items and results.
`default_nettype none
interface icca_in_if;
  logic valid;
  logic ready;
  logic [16:0] start_seconds;
  logic [16:0] duration_seconds;
  logic last_entry;
  modport source (output valid, start_seconds, duration_seconds, last_entry, input ready);
  modport sink (input valid, start_seconds, duration_seconds, last_entry, output ready);
endinterface

interface icca_out_if;
  logic valid;
  logic ready;
  logic [4:0] entry_index;
  logic [4:0] column;
  logic [5:0] column_count;
  logic entries_dropped;
  logic last_result;
  modport source (output valid, entry_index, column, column_count, entries_dropped,
                  last_result, input ready);
  modport sink (input valid, entry_index, column, column_count, entries_dropped,
                last_result, output ready);
endinterface
`default_nettype wire

/* rtl/icca_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module icca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/interval_cluster_column_assign.sv */
// Top level: interval load, sort, clustering and first-fit column assignment.
// Load: one transfer per cycle while idle; the last item starts the layout pass.
// Sort: insertion sort by start; per entry a key fetch (SORT_KEY), then compare steps
//   (SORT_CMP) that shift larger entries up. Cluster scan reads entries in sorted order;
//   first fit tries columns from 0 upward for each entry; output emits one result per
//   entry and stalls under back-pressure. Input is held off until layout ends.
// Reset (async, active low) clears control only; RAM contents are undefined until written.
`default_nettype none
module interval_cluster_column_assign
  import icca_pkg::*;
#(
  parameter int unsigned MaxEntries = MaxEntriesDef
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  icca_in_if.sink     in_i,
  icca_out_if.source  out_o
);
  localparam int unsigned AW = $clog2(MaxEntries);
  localparam int unsigned NW = $clog2(MaxEntries + 1);
  localparam int unsigned LdW = EndW + StartW;   // {end, start}
  localparam int unsigned OrdW = LdW + AW;       // {end, start, load index}

  state_e state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;          // loaded count
  logic ovf_q, ovf_d;
  // sort: i outer, j inner; key is {end, start} of entry i
  logic [NW-1:0] i_q, i_d, j_q, j_d;
  logic key_new_q, key_new_d;           // key arrives from the load RAM this cycle
  logic [LdW-1:0] key_q, key_d;
  // cluster scan and first fit
  logic [NW-1:0] first_q, first_d, pos_q, pos_d, k_q, k_d;
  logic [EndW-1:0] cend_q, cend_d;
  logic [NW-1:0] ncol_q, ncol_d;
  logic [NW-1:0] c_q, c_d;
  logic [StartW-1:0] es_q, es_d;        // start of current entry in first fit
  logic [EndW-1:0] ee_q, ee_d;
  // output register
  logic ov_q, ov_d;
  logic [IdxW-1:0] oi_q, oi_d, oc_q, oc_d;
  logic [CntW-1:0] on_q, on_d;
  logic od_q, od_d, ol_q, ol_d;

  // RAMs: load data by load index; sorted order packed with start and end; column ends; assigned columns
  logic ld_we, ord_we, ce_we, ac_we;
  logic [AW-1:0] ld_wa, ld_ra, ord_wa, ord_ra, ce_wa, ce_ra, ac_wa, ac_ra;
  logic [LdW-1:0] ld_wd, ld_rd;
  logic [OrdW-1:0] ord_wd, ord_rd;
  logic [EndW-1:0] ce_wd, ce_rd;
  logic [AW-1:0] ac_wd, ac_rd;

  icca_ram #(.Width(LdW), .Depth(MaxEntries)) u_load (.clk_i, .we_i(ld_we),
    .waddr_i(ld_wa), .wdata_i(ld_wd), .raddr_i(ld_ra), .rdata_o(ld_rd));
  icca_ram #(.Width(OrdW), .Depth(MaxEntries)) u_order (.clk_i, .we_i(ord_we),
    .waddr_i(ord_wa), .wdata_i(ord_wd), .raddr_i(ord_ra), .rdata_o(ord_rd));
  icca_ram #(.Width(EndW), .Depth(MaxEntries)) u_colend (.clk_i, .we_i(ce_we),
    .waddr_i(ce_wa), .wdata_i(ce_wd), .raddr_i(ce_ra), .rdata_o(ce_rd));
  icca_ram #(.Width(AW), .Depth(MaxEntries)) u_assign (.clk_i, .we_i(ac_we),
    .waddr_i(ac_wa), .wdata_i(ac_wd), .raddr_i(ac_ra), .rdata_o(ac_rd));

  // Fields of the order word read last cycle.
  logic [AW-1:0] rd_idx;
  logic [StartW-1:0] rd_start;
  logic [EndW-1:0] rd_end;
  assign rd_idx   = ord_rd[AW-1:0];
  assign rd_start = ord_rd[AW +: StartW];
  assign rd_end   = ord_rd[AW+StartW +: EndW];

  // Current sort key: straight from the RAM on the first compare of an entry.
  logic [LdW-1:0] key_c;
  logic [StartW-1:0] key_start;
  assign key_c = key_new_q ? ld_rd : key_q;
  assign key_start = key_c[StartW-1:0];

  logic in_fire, out_fire;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign in_i.ready = (state_q == ST_LOAD);
  assign out_o.valid = ov_q;
  assign out_o.entry_index = oi_q;
  assign out_o.column = oc_q;
  assign out_o.column_count = on_q;
  assign out_o.entries_dropped = od_q;
  assign out_o.last_result = ol_q;

  logic [StartW-1:0] s_in;
  logic [EndW-1:0] e_in;
  assign s_in = wrap17(in_i.start_seconds);
  assign e_in = calc_end(s_in, wrap17(in_i.duration_seconds));

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; ovf_d = ovf_q;
    i_d = i_q; j_d = j_q; key_d = key_q; key_new_d = key_new_q;
    first_d = first_q; pos_d = pos_q; k_d = k_q; cend_d = cend_q;
    ncol_d = ncol_q; c_d = c_q; es_d = es_q; ee_d = ee_q;
    ov_d = ov_q; oi_d = oi_q; oc_d = oc_q; on_d = on_q; od_d = od_q; ol_d = ol_q;
    ld_we = 1'b0; ord_we = 1'b0; ce_we = 1'b0; ac_we = 1'b0;
    ld_wa = cnt_q[AW-1:0]; ld_wd = {e_in, s_in}; ld_ra = '0;
    ord_wa = '0; ord_wd = '0; ord_ra = '0;
    ce_wa = '0; ce_wd = ee_q; ce_ra = '0;
    ac_wa = '0; ac_wd = c_q[AW-1:0]; ac_ra = '0;
    if (out_fire) ov_d = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (cnt_q < NW'(MaxEntries)) begin
            ld_we = 1'b1; cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last_entry) begin
            i_d = '0; state_d = ST_SORT_KEY;
          end
        end
      end
      ST_SORT_KEY: begin
        // fetch entry i and order[i-1] together
        if (i_q == cnt_q) begin
          pos_d = '0; state_d = ST_CL_RD;
        end else begin
          ld_ra = i_q[AW-1:0]; ord_ra = AW'(i_q - 1'b1);
          j_d = i_q; key_new_d = 1'b1; state_d = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        // shift order[j-1] up while its start is above the key; equal starts stay
        key_d = key_c; key_new_d = 1'b0;
        ord_we = 1'b1; ord_wa = j_q[AW-1:0];
        if (j_q != '0 && rd_start > key_start) begin
          ord_wd = ord_rd; j_d = j_q - 1'b1;
          ord_ra = AW'(j_q - 2'd2);
        end else begin
          ord_wd = {key_c, i_q[AW-1:0]};
          i_d = i_q + 1'b1; state_d = ST_SORT_KEY;
        end
      end
      ST_CL_RD: begin
        // start a cluster at pos, or finish the run
        if (pos_q == cnt_q) begin
          state_d = ST_LOAD; cnt_d = '0; ovf_d = 1'b0;
        end else begin
          ord_ra = pos_q[AW-1:0]; first_d = pos_q; state_d = ST_CL_CHK;
        end
      end
      ST_CL_CHK: begin
        // entry joins while its start is strictly below the running end
        if (pos_q == first_q || {1'b0, rd_start} < cend_q) begin
          if (pos_q == first_q || rd_end > cend_q) cend_d = rd_end;
          pos_d = pos_q + 1'b1;
          if (pos_q + 1'b1 == cnt_q) begin
            k_d = first_q; ncol_d = '0; state_d = ST_COL_RD;
          end else begin
            ord_ra = AW'(pos_q + 1'b1);
          end
        end else begin
          k_d = first_q; ncol_d = '0; state_d = ST_COL_RD;
        end
      end
      ST_COL_RD: begin
        if (k_q == pos_q) begin
          k_d = first_q; state_d = ST_OUT_RD;
        end else begin
          ord_ra = k_q[AW-1:0]; state_d = ST_COL_ENT;
        end
      end
      ST_COL_ENT: begin
        es_d = rd_start; ee_d = rd_end; c_d = '0; ce_ra = '0;
        state_d = ST_COL_CHK;
      end
      ST_COL_CHK: begin
        // lowest column whose last end is at or before the start, else a new one
        if (c_q == ncol_q || ce_rd <= {1'b0, es_q}) begin
          if (c_q == ncol_q) ncol_d = ncol_q + 1'b1;
          ce_we = 1'b1; ce_wa = c_q[AW-1:0];
          ac_we = 1'b1; ac_wa = k_q[AW-1:0];
          k_d = k_q + 1'b1; state_d = ST_COL_RD;
        end else begin
          c_d = c_q + 1'b1; ce_ra = AW'(c_q + 1'b1);
        end
      end
      ST_OUT_RD: begin
        if (k_q == pos_q) begin
          state_d = ST_CL_RD;
        end else if (!ov_q || out_fire) begin
          ord_ra = k_q[AW-1:0]; ac_ra = k_q[AW-1:0]; state_d = ST_OUT_EMIT;
        end
      end
      ST_OUT_EMIT: begin
        ov_d = 1'b1; oi_d = IdxW'(rd_idx); oc_d = IdxW'(ac_rd);
        on_d = CntW'(ncol_q); od_d = ovf_q;
        ol_d = (k_q + 1'b1 == cnt_q);
        k_d = k_q + 1'b1; state_d = ST_OUT_RD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; cnt_q <= '0; ovf_q <= 1'b0; ov_q <= 1'b0;
      i_q <= '0; j_q <= '0; key_new_q <= 1'b0; k_q <= '0; pos_q <= '0;
      first_q <= '0; ncol_q <= '0; c_q <= '0; cend_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovf_q <= ovf_d; ov_q <= ov_d;
      i_q <= i_d; j_q <= j_d; key_new_q <= key_new_d; k_q <= k_d; pos_q <= pos_d;
      first_q <= first_d; ncol_q <= ncol_d; c_q <= c_d; cend_q <= cend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d; es_q <= es_d; ee_q <= ee_d;
    oi_q <= oi_d; oc_q <= oc_d; on_q <= on_d; od_q <= od_d; ol_q <= ol_d;
  end

  // Result valid and entry index hold while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.entry_index))
    else $error("result changed under stall");
  // No input accepted during layout.
  a_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_LOAD |-> !in_i.ready) else $error("load during layout");
  // Load count never exceeds capacity.
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(MaxEntries)) else $error("count overflow");
  // A new result is only loaded into an empty output register.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT_EMIT |-> !out_o.valid) else $error("result overwritten");
endmodule
`default_nettype wire

/* sim/tb_interval_cluster_column_assign.sv */
// Testbench for interval cluster column assignment: directed and random load sets checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_interval_cluster_column_assign;
  import icca_pkg::*;

  localparam int unsigned Cap = MaxEntriesDef;
  localparam int unsigned Day = 86400;
  localparam int unsigned IdleLimit = 200000;

  typedef struct packed {
    logic [16:0] start_s;
    logic [16:0] dur_s;
    logic        last;
  } interval_t;

  typedef struct packed {
    logic [4:0] idx;
    logic [4:0] col;
    logic [5:0] ncol;
    logic       dropped;
    logic       last;
  } placement_t;

  logic clk_i;
  logic rst_ni;

  icca_in_if  in_ch ();
  icca_out_if out_ch ();

  interval_cluster_column_assign uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  interval_t  pending_q[$];
  placement_t placement_q[$];
  int         errors;
  int         idle_cycles;

  // Predictor state: the current load set.
  int unsigned set_start[Cap];
  int unsigned set_end[Cap];
  int unsigned set_count;
  bit          set_dropped;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Accept one interval into the set; on the last one lay out the set and queue placements.
  task automatic predict_layout(input interval_t it);
    int unsigned s, d, e, n, pos, first, ncol, c, clend, key, j;
    int unsigned order[Cap];
    int unsigned colend[Cap];
    int unsigned acol[Cap];
    placement_t p;
    s = it.start_s;
    if (s >= Day) s -= Day;
    d = it.dur_s;
    if (d >= Day) d -= Day;
    e = s + d;
    if (e >= Day) e -= Day;
    if (e < s) e += Day;
    if (set_count < Cap) begin
      set_start[set_count] = s;
      set_end[set_count] = e;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!it.last) return;
    n = set_count;
    // Insertion sort by start, ties kept in load order.
    for (int unsigned i = 0; i < n; i++) begin
      key = i;
      j = i;
      while (j > 0 && set_start[order[j-1]] > set_start[key]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    pos = 0;
    while (pos < n) begin
      first = pos;
      ncol = 0;
      clend = set_end[order[pos]];
      pos++;
      // Chained overlap: strictly below the running cluster end.
      while (pos < n && set_start[order[pos]] < clend) begin
        if (set_end[order[pos]] > clend) clend = set_end[order[pos]];
        pos++;
      end
      for (int unsigned k = first; k < pos; k++) begin
        for (c = 0; c < ncol; c++)
          if (colend[c] <= set_start[order[k]]) break;
        if (c == ncol) ncol++;
        colend[c] = set_end[order[k]];
        acol[k] = c;
      end
      for (int unsigned k = first; k < pos; k++) begin
        p.idx = 5'(order[k]);
        p.col = 5'(acol[k]);
        p.ncol = 6'(ncol);
        p.dropped = set_dropped;
        p.last = (k + 1 == n);
        placement_q.push_back(p);
      end
    end
    set_count = 0;
    set_dropped = 1'b0;
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic interval_t rand_interval(input bit last);
    interval_t it;
    int unsigned r;
    r = $urandom_range(0, 9);
    // Mostly dense intervals within a few hours so clusters form.
    it.start_s = (r < 7) ? 17'($urandom_range(30000, 40000)) : 17'($urandom_range(0, 131071));
    r = $urandom_range(0, 9);
    if (r < 2) it.dur_s = '0;
    else if (r < 8) it.dur_s = 17'($urandom_range(1, 3 * 3600));
    else it.dur_s = 17'($urandom_range(0, 131071));
    it.last = last;
    return it;
  endfunction

  // Driver: one pending interval at a time, random gaps between transfers.
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.start_seconds <= '0;
      in_ch.duration_seconds <= '0;
      in_ch.last_entry <= 1'b0;
      in_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold until accepted
    end else begin
      if (in_ch.valid) begin
        predict_layout(pending_q.pop_front());
        gap = gap_len();
      end else begin
        gap = in_gap;
      end
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        in_gap <= gap - 1;
      end else if (pending_q.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.start_seconds <= pending_q[0].start_s;
        in_ch.duration_seconds <= pending_q[0].dur_s;
        in_ch.last_entry <= pending_q[0].last;
        in_gap <= 0;
      end else begin
        in_ch.valid <= 1'b0;
        in_gap <= 0;
      end
    end
  end

  // Monitor: random back-pressure, field checks against the oldest expected placement.
  int unsigned out_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    placement_t got, want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.entry_index, out_ch.column, out_ch.column_count,
               out_ch.entries_dropped, out_ch.last_result};
        if (placement_q.size() == 0) begin
          $display("%0t: unexpected placement %p", $time, got);
          errors++;
        end else begin
          want = placement_q.pop_front();
          if (got.idx !== want.idx) begin
            $display("%0t: entry_index exp %0d got %0d", $time, want.idx, got.idx);
            errors++;
          end
          if (got.col !== want.col) begin
            $display("%0t: column exp %0d got %0d", $time, want.col, got.col);
            errors++;
          end
          if (got.ncol !== want.ncol) begin
            $display("%0t: column_count exp %0d got %0d", $time, want.ncol, got.ncol);
            errors++;
          end
          if (got.dropped !== want.dropped) begin
            $display("%0t: entries_dropped exp %0b got %0b", $time, want.dropped,
                     got.dropped);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_result exp %0b got %0b", $time, want.last, got.last);
            errors++;
          end
        end
      end
      if (out_gap != 0) begin
        out_ch.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap <= gap_len();
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni && idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_set(input int unsigned n, input bit wide);
    interval_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it = rand_interval(i == n - 1);
      if (!wide) it.start_s = 17'(it.start_s % Day);
      pending_q.push_back(it);
    end
  endtask

  initial begin
    interval_t it;
    int unsigned n;
    errors = 0;
    set_count = 0;
    set_dropped = 1'b0;
    rst_ni = 1'b0;
    // Directed: field extremes, wrap past midnight, out-of-range values, equal starts.
    pending_q.push_back('{17'd0, 17'd0, 1'b1});
    pending_q.push_back('{17'd86399, 17'd86399, 1'b0});
    pending_q.push_back('{17'h1FFFF, 17'h1FFFF, 1'b0});
    pending_q.push_back('{17'd86400, 17'd86400, 1'b0});
    pending_q.push_back('{17'd100, 17'd50, 1'b0});
    pending_q.push_back('{17'd100, 17'd10, 1'b0});
    pending_q.push_back('{17'd150, 17'd20, 1'b0});
    pending_q.push_back('{17'd110, 17'd100, 1'b0});
    pending_q.push_back('{17'd80000, 17'd20000, 1'b0});
    pending_q.push_back('{17'd5000, 17'd3600, 1'b0});
    pending_q.push_back('{17'd8600, 17'd60, 1'b1});
    // Set one over capacity, last dropped but still triggers layout.
    for (int unsigned i = 0; i <= Cap; i++) begin
      it = rand_interval(i == Cap);
      pending_q.push_back(it);
    end
    // Random sets: mostly small, a few near, at or over capacity.
    n = 0;
    while (n < 176) begin
      int unsigned sz;
      sz = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(Cap - 2, Cap + 3);
      push_set(sz, 1'b1);
      n += sz;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    wait (placement_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
